FILE: rtl/core/u8fold_pkg.sv
// Shared types, codes and fold tables for the UTF-8 to upper-case ASCII fold.
// Used by u8fold_decode and utf8_fold_to_upper_ascii; no dependencies.
`timescale 1ns / 1ps

package u8fold_pkg;

    localparam int unsigned MAX_CAPACITY = 256;
    localparam int unsigned LIM_W        = 17;
    localparam int unsigned CAP_W        = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_C3   = 2'd1;
    localparam logic [1:0] LEAD_C4   = 2'd2;
    localparam logic [1:0] LEAD_C5   = 2'd3;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_C3     = 8'hC3;
    localparam logic [7:0] BYTE_C4     = 8'hC4;
    localparam logic [7:0] BYTE_C5     = 8'hC5;
    localparam logic [7:0] BYTE_SHARP  = 8'h9F;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] FIRST_PRINT = 8'h20;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_Z = 8'h5A;
    localparam logic [7:0] CH_Q = 8'h3F;

    typedef struct packed {
        logic [1:0] pending_lead;
        logic       skipping_tail;
        logic [7:0] written_count;
    } u8fold_state_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] out_char;
        logic [7:0] char_count;
        logic       run_last;
    } u8fold_res_t;

    function automatic logic [7:0] fold_c3(input logic [7:0] b);
        logic [7:0] ch;
        case (b) inside
            [8'h80:8'h85], 8'hA4: ch = CH_A;
            [8'h88:8'h8B]:        ch = CH_E;
            [8'h8C:8'h8F]:        ch = CH_I;
            [8'h92:8'h98], 8'hB6: ch = CH_O;
            [8'h99:8'h9C], 8'hBC: ch = CH_U;
            default:              ch = CH_Q;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] fold_c4(input logic [7:0] b);
        logic [7:0] ch;
        case (b) inside
            8'h84, 8'h85: ch = CH_A;
            8'h86, 8'h87: ch = CH_C;
            8'h98, 8'h99: ch = CH_E;
            default:      ch = CH_Q;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] fold_c5(input logic [7:0] b);
        logic [7:0] ch;
        case (b) inside
            8'h81, 8'h82:  ch = CH_L;
            8'h83, 8'h84:  ch = CH_N;
            8'h9A, 8'h9B:  ch = CH_S;
            [8'hB9:8'hBC]: ch = CH_Z;
            default:       ch = CH_Q;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/u8fold_decode.sv
// Per-byte decode: next state and up to two result beats for one text byte.
// Depends on u8fold_pkg.
`timescale 1ns / 1ps

module u8fold_decode (
    input  logic [7:0]                       text_byte,
    input  u8fold_pkg::u8fold_state_t        state_cur,
    input  logic [u8fold_pkg::LIM_W-1:0]     limit,
    output u8fold_pkg::u8fold_state_t        state_nxt,
    output logic [1:0]                       res_cnt,
    output u8fold_pkg::u8fold_res_t          res0,
    output u8fold_pkg::u8fold_res_t          res1
);
    import u8fold_pkg::*;

    logic [7:0]       c;
    logic [LIM_W-1:0] c1_ext;
    logic [LIM_W-1:0] c2_ext;
    logic             ok1;
    logic             ok2;
    logic [1:0]       want;
    logic [7:0]       ch;
    logic             with_end;
    logic [1:0]       n_chr;
    logic [7:0]       end_count;

    assign c      = state_cur.written_count;
    assign c1_ext = LIM_W'(c) + LIM_W'(1);
    assign c2_ext = LIM_W'(c) + LIM_W'(2);
    assign ok1    = (c != 8'hFF) && (c1_ext < limit);
    assign ok2    = ok1 && (c != 8'hFE) && (c2_ext < limit);

    always_comb
    begin
        state_nxt = state_cur;
        want      = 2'd0;
        ch        = CH_Q;
        with_end  = 1'b0;
        if (text_byte == BYTE_NUL)
        begin
            with_end  = 1'b1;
            want      = (state_cur.pending_lead != LEAD_NONE) ? 2'd1 : 2'd0;
            state_nxt = '0;
        end
        else if (state_cur.pending_lead != LEAD_NONE)
        begin
            state_nxt.pending_lead = LEAD_NONE;
            want = 2'd1;
            case (state_cur.pending_lead)
                LEAD_C3:
                begin
                    if (text_byte == BYTE_SHARP)
                    begin
                        want = 2'd2;
                        ch   = CH_S;
                    end
                    else
                    begin
                        ch = fold_c3(text_byte);
                    end
                end
                LEAD_C4: ch = fold_c4(text_byte);
                default: ch = fold_c5(text_byte);
            endcase
        end
        else if (state_cur.skipping_tail && ((text_byte & CONT_MASK) == CONT_CODE))
        begin
            want = 2'd0;
        end
        else
        begin
            state_nxt.skipping_tail = 1'b0;
            if (text_byte < CONT_CODE)
            begin
                if (text_byte >= LOWER_A && text_byte <= LOWER_Z)
                begin
                    want = 2'd1;
                    ch   = text_byte - CASE_OFFSET;
                end
                else if (text_byte >= FIRST_PRINT)
                begin
                    want = 2'd1;
                    ch   = text_byte;
                end
            end
            else if (text_byte == BYTE_C3)
            begin
                state_nxt.pending_lead = LEAD_C3;
            end
            else if (text_byte == BYTE_C4)
            begin
                state_nxt.pending_lead = LEAD_C4;
            end
            else if (text_byte == BYTE_C5)
            begin
                state_nxt.pending_lead = LEAD_C5;
            end
            else
            begin
                want = 2'd1;
                state_nxt.skipping_tail = 1'b1;
            end
        end

        if (want == 2'd2 && ok2)
            n_chr = 2'd2;
        else if (want != 2'd0 && ok1)
            n_chr = 2'd1;
        else
            n_chr = 2'd0;

        end_count = c + 8'(n_chr);
        if (text_byte != BYTE_NUL)
            state_nxt.written_count = end_count;

        res_cnt = n_chr + 2'(with_end);

        res0.item_kind  = KIND_CHAR;
        res0.out_char   = ch;
        res0.char_count = c + 8'd1;
        res0.run_last   = (res_cnt == 2'd1);
        if (n_chr == 2'd0)
        begin
            res0.item_kind  = KIND_END;
            res0.out_char   = BYTE_NUL;
            res0.char_count = end_count;
        end

        res1.item_kind  = KIND_CHAR;
        res1.out_char   = ch;
        res1.char_count = c + 8'd2;
        res1.run_last   = 1'b1;
        if (n_chr != 2'd2)
        begin
            res1.item_kind  = KIND_END;
            res1.out_char   = BYTE_NUL;
            res1.char_count = end_count;
        end
    end

endmodule

FILE: rtl/core/utf8_fold_to_upper_ascii.sv
// Top level of the UTF-8 to upper-case ASCII fold: state, result queue, config.
// Depends on u8fold_pkg and u8fold_decode.
`timescale 1ns / 1ps
//
//  channel   dir  beat contents (low bit first)
//  s_axis    in   tdata[7:0] text_byte
//  m_axis    out  tdata[7:0] out_char, [15:8] char_count; tuser item_kind; tlast run_last
//  cfg       in   cfg_wr_data[8:0] buffer_capacity, written when cfg_wr_en is high
//
//  One input beat per cycle while s_axis_tready is high; each byte is decoded in the
//  cycle it is taken into a two-entry result queue, which drains one beat per cycle
//  while m_axis_tready is high. A byte giving two results (sharp s, or lead byte before
//  terminator) holds s_axis_tready low while both queue entries are full.
//  Reset clears the decode state, empties the queue and sets capacity to 256.
//  m_axis stalls hold the queue; s_axis takes a byte while the last queued beat leaves.

module utf8_fold_to_upper_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_char, [15:8] char_count
    output logic        m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [u8fold_pkg::CAP_W-1:0] cfg_wr_data
);
    import u8fold_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    u8fold_state_t    state_reg;
    u8fold_state_t    state_next;
    u8fold_res_t      slot0_reg;
    u8fold_res_t      slot0_next;
    u8fold_res_t      slot1_reg;
    u8fold_res_t      slot1_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    logic [LIM_W-1:0] limit;
    u8fold_state_t    dec_state;
    logic [1:0]       dec_cnt;
    u8fold_res_t      dec_res0;
    u8fold_res_t      dec_res1;
    logic             push;
    logic             pop;

    assign limit = (LIM_W'(cap_reg) > LIM_W'(MAX_CAPACITY)) ? LIM_W'(MAX_CAPACITY)
                                                            : LIM_W'(cap_reg);

    u8fold_decode u_decode (
        .text_byte (s_axis_tdata),
        .state_cur (state_reg),
        .limit     (limit),
        .state_nxt (dec_state),
        .res_cnt   (dec_cnt),
        .res0      (dec_res0),
        .res1      (dec_res1)
    );

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign m_axis_tdata  = {slot0_reg.char_count, slot0_reg.out_char};
    assign m_axis_tuser  = slot0_reg.item_kind;
    assign m_axis_tlast  = slot0_reg.run_last;

    always_comb
    begin
        state_next = state_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (push)
        begin
            state_next = dec_state;
            slot0_next = dec_res0;
            slot1_next = dec_res1;
            cnt_next   = dec_cnt;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            state_reg <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && (cnt_reg == 2'd2)))
        else $error("input taken with result queue full");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> m_axis_tlast)
        else $error("end beat without tlast");

    a_char_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_CHAR)) |-> (m_axis_tdata[15:8] != 8'd0))
        else $error("character beat with zero count");

    a_nul_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (s_axis_tdata == BYTE_NUL)) |=> (state_reg == '0))
        else $error("terminator left decode state set");

endmodule

FILE: bench/tb_utf8_fold_to_upper_ascii.sv
// Self-checking bench for utf8_fold_to_upper_ascii: directed and random UTF-8 text,
// capacity sweeps, random stalls on both streams and one long output hold-off.
// Depends on u8fold_pkg and the utf8_fold_to_upper_ascii RTL.
`timescale 1ns / 1ps

module tb_utf8_fold_to_upper_ascii;

    import u8fold_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_BOUND = 4000;

    class upper_fold_board;
        u8fold_res_t folded_beats[$];
        u8fold_res_t byte_beats[$];
        logic [1:0]       lead_waiting;
        logic             in_tail;
        logic [7:0]       written;
        logic [CAP_W-1:0] capacity;
        int errors;
        int texts;
        int chars;
        int double_beats;
        int peak_count;

        function new();
            lead_waiting = LEAD_NONE;
            in_tail      = 1'b0;
            written      = 8'd0;
            capacity     = CAP_RESET;
            errors       = 0;
            texts        = 0;
            chars        = 0;
            double_beats = 0;
            peak_count   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int pending();
            return folded_beats.size();
        endfunction

        function logic [7:0] c3_base(logic [7:0] b);
            if ((b >= 8'h80 && b <= 8'h85) || b == 8'hA4) return CH_A;
            if (b >= 8'h88 && b <= 8'h8B) return CH_E;
            if (b >= 8'h8C && b <= 8'h8F) return CH_I;
            if ((b >= 8'h92 && b <= 8'h98) || b == 8'hB6) return CH_O;
            if ((b >= 8'h99 && b <= 8'h9C) || b == 8'hBC) return CH_U;
            return CH_Q;
        endfunction

        function logic [7:0] c4_base(logic [7:0] b);
            if (b == 8'h84 || b == 8'h85) return CH_A;
            if (b == 8'h86 || b == 8'h87) return CH_C;
            if (b == 8'h98 || b == 8'h99) return CH_E;
            return CH_Q;
        endfunction

        function logic [7:0] c5_base(logic [7:0] b);
            if (b == 8'h81 || b == 8'h82) return CH_L;
            if (b == 8'h83 || b == 8'h84) return CH_N;
            if (b == 8'h9A || b == 8'h9B) return CH_S;
            if (b >= 8'hB9 && b <= 8'hBC) return CH_Z;
            return CH_Q;
        endfunction

        function void write_char(logic [7:0] ch);
            u8fold_res_t r;
            int limit;
            limit = (int'(capacity) > int'(MAX_CAPACITY)) ? int'(MAX_CAPACITY)
                                                          : int'(capacity);
            if (int'(written) + 1 >= limit) return;
            if (written == 8'hFF) return;
            written      = written + 8'd1;
            r.item_kind  = KIND_CHAR;
            r.out_char   = ch;
            r.char_count = written;
            r.run_last   = 1'b0;
            byte_beats.push_back(r);
            chars++;
            if (int'(written) > peak_count) peak_count = int'(written);
        endfunction

        function void note_byte(logic [7:0] b);
            u8fold_res_t r;
            logic [1:0] lead;
            byte_beats.delete();
            if (b == BYTE_NUL)
            begin
                if (lead_waiting != LEAD_NONE) write_char(CH_Q);
                r.item_kind  = KIND_END;
                r.out_char   = 8'd0;
                r.char_count = written;
                r.run_last   = 1'b0;
                byte_beats.push_back(r);
                lead_waiting = LEAD_NONE;
                in_tail      = 1'b0;
                written      = 8'd0;
                texts++;
            end
            else if (lead_waiting != LEAD_NONE)
            begin
                lead = lead_waiting;
                lead_waiting = LEAD_NONE;
                if (lead == LEAD_C3 && b == BYTE_SHARP)
                begin
                    write_char(CH_S);
                    write_char(CH_S);
                end
                else if (lead == LEAD_C3)
                begin
                    write_char(c3_base(b));
                end
                else if (lead == LEAD_C4)
                begin
                    write_char(c4_base(b));
                end
                else
                begin
                    write_char(c5_base(b));
                end
            end
            else
            begin
                if (in_tail)
                begin
                    if ((b & CONT_MASK) == CONT_CODE) return;
                    in_tail = 1'b0;
                end
                if (b < 8'h80)
                begin
                    if (b >= LOWER_A && b <= LOWER_Z) write_char(b - CASE_OFFSET);
                    else if (b >= FIRST_PRINT) write_char(b);
                end
                else if (b == BYTE_C3)
                begin
                    lead_waiting = LEAD_C3;
                end
                else if (b == BYTE_C4)
                begin
                    lead_waiting = LEAD_C4;
                end
                else if (b == BYTE_C5)
                begin
                    lead_waiting = LEAD_C5;
                end
                else
                begin
                    write_char(CH_Q);
                    in_tail = 1'b1;
                end
            end
            if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].run_last = 1'b1;
            if (byte_beats.size() > 1) double_beats++;
            foreach (byte_beats[i]) folded_beats.push_back(byte_beats[i]);
        endfunction

        function void check_beat(u8fold_res_t got);
            u8fold_res_t want;
            if (folded_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: kind %0d char %02h count %0d last %0d",
                             got.item_kind, got.out_char, got.char_count, got.run_last);
                return;
            end
            want = folded_beats.pop_front();
            if (got.item_kind !== want.item_kind || got.out_char !== want.out_char ||
                got.char_count !== want.char_count || got.run_last !== want.run_last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"beat mismatch: expected kind %0d char %02h count %0d last %0d,",
                              " got kind %0d char %02h count %0d last %0d"},
                             want.item_kind, want.out_char, want.char_count, want.run_last,
                             got.item_kind, got.out_char, got.char_count, got.run_last);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'd0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [15:0]      m_axis_tdata;
    logic             m_axis_tuser;
    logic             m_axis_tlast;
    logic             cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    int send_idle = 15;
    int recv_idle = 57;
    logic hold_req = 1'b0;
    upper_fold_board board;

    logic [7:0] directed_text [0:24] = '{
        8'h61, 8'h7A, 8'h41, 8'h7E, 8'h7F, 8'h01, 8'h1F, 8'h20,
        8'hC3, 8'h9F, 8'hC3, 8'h84, 8'hC4, 8'h87, 8'hC5, 8'hBC,
        8'hC3, 8'h41, 8'hE2, 8'h82, 8'hAC, 8'h41, 8'hFF, 8'hC5, 8'h00
    };

    utf8_fold_to_upper_ascii DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // check the outgoing beat before noting the incoming one
    always @(posedge clk)
    begin
        if (rst_n && board != null)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_beat('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                                   m_axis_tlast});
            if (s_axis_tvalid && s_axis_tready)
                board.note_byte(s_axis_tdata);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(0, 2))
            0:       return BYTE_C3;
            1:       return BYTE_C4;
            default: return BYTE_C5;
        endcase
    endfunction

    task automatic send_random_text(input int pieces);
        int r;
        int k;
        int c;
        for (k = 0; k < pieces; k++)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 35)
                send_byte(8'($urandom_range(8'h61, 8'h7A)));
            else if (r < 50)
                send_byte(8'($urandom_range(8'h20, 8'h7F)));
            else if (r < 55)
                send_byte(8'($urandom_range(8'h01, 8'h1F)));
            else if (r < 75)
            begin
                send_byte(pick_lead());
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (r < 85)
            begin
                send_byte(8'($urandom_range(8'hC6, 8'hF7)));
                for (c = int'($urandom_range(1, 3)); c > 0; c--)
                    send_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            else if (r < 93)
                send_byte(8'($urandom_range(8'h01, 8'hFF)));
            else
            begin
                send_byte(pick_lead());
                send_byte(8'($urandom_range(8'h01, 8'hFF)));
            end
        end
        if ($urandom_range(0, 9) == 0) send_byte(pick_lead());
        send_byte(BYTE_NUL);
    endtask

    task automatic settle_outputs();
        int w;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        for (w = 0; w < DRAIN_BOUND && board.pending() > 0; w++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.set_capacity(v);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_texts, input int pieces);
        settle_outputs();
        write_capacity(cap);
        repeat (n_texts) send_random_text(pieces);
    endtask

    initial
    begin
        int k;
        board = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 15;
        recv_idle = 57;
        for (k = 0; k < 25; k++) send_byte(directed_text[k]);
        run_phase(9'd0, 1, 10);
        run_phase(9'd1, 1, 10);
        run_phase(9'd2, 2, 8);
        run_phase(9'd5, 2, 12);

        send_idle = 57;
        recv_idle = 15;
        settle_outputs();
        write_capacity(9'd511);
        hold_req = 1'b1;
        repeat (3) send_random_text(20);
        // push the count to saturation with one long printable text
        run_phase(9'd300, 0, 0);
        for (k = 0; k < 262; k++) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        send_byte(BYTE_NUL);

        send_idle = 0;
        recv_idle = 0;
        repeat (3) run_phase(CAP_W'($urandom_range(0, 511)), 2, 12);
        run_phase(CAP_RESET, 2, 12);

        settle_outputs();
        if (board.pending() > 0)
        begin
            $display("%0d expected beats never arrived", board.pending());
            board.errors += board.pending();
        end
        $display("covered %0d texts, %0d folded characters, %0d two-beat bytes",
                 board.texts, board.chars, board.double_beats);
        $display("capacities 0 to 511 swept, peak count %0d, %0d failures",
                 board.peak_count, board.errors);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/u8fold_pkg.sv
rtl/core/u8fold_decode.sv
rtl/core/utf8_fold_to_upper_ascii.sv
bench/tb_utf8_fold_to_upper_ascii.sv
